// ===== sv/modbus_response_checker_unit_assert.svh =====
// Assertion macros for the Modbus RTU reply checker.
// Used by the checker module. The file depends on nothing else.
`ifndef MODBUS_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_RESPONSE_CHECKER_UNIT_ASSERT_SVH

// Checks the condition c in the same cycle whenever a holds.
`define MRC_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("modbus response checker: assertion failed");

// Checks the condition c in the next cycle whenever a holds.
`define MRC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("modbus response checker: assertion failed");

`endif

// ===== sv/mrc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the reply checker.
// No dependencies.
package mrc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [6:0]  MIN_LEN_RESET = 7'd25;
  localparam int          READ_FIRST    = 3;
  localparam int          READ_COUNT    = 12;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_CRC_BAD = 2'd2
  } frame_status_t;

  // One byte through the reflected CRC, unrolled over its eight bits.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_response_checker_unit.sv =====
// Modbus RTU reply checker: CRC-16/MODBUS check, length check and reading extraction.
// Depends on mrc_pkg.
//
// The block takes one reply byte per cycle unless in_stall holds it, and gives one
// result word per frame, in the cycle after the byte that carries end_of_frame. The CRC
// update is a single unrolled byte-wide XOR network between the frame state registers,
// and the status is formed from it and registered in the result stage. The CRC lags
// the input by two bytes through a two-byte delay line, so the trailer itself is never
// hashed. Bytes beyond MAX_FRAME_BYTES are dropped. While a result waits to be taken,
// further bytes are still accepted; only a final byte is held back until the result
// register is free. min_frame_length may be written at any time the block is idle.
module modbus_response_checker_unit #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [15:0] crc_computed,
  output logic [15:0] crc_received,
  output logic [15:0] voltage_raw,
  output logic [15:0] current_raw,
  output logic [15:0] power_raw,
  output logic [15:0] energy_raw,
  output logic [15:0] frequency_raw,
  output logic [15:0] power_factor_raw
);
  import mrc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  logic [6:0]    min_frame_length;
  logic [15:0]   running_crc, running_crc_next;
  logic [CW-1:0] kept_byte_count, kept_byte_count_next;
  logic [7:0]    trailer_delay [2];
  logic [7:0]    trailer_delay_next [2];
  logic [7:0]    reading_bytes [READ_COUNT];
  logic [7:0]    reading_bytes_next [READ_COUNT];
  logic          in_accept, out_take, keep;
  frame_status_t status_next;
  logic [15:0]   recv_next;

  assign cfg_ready = 1'b1;
  assign out_take  = out_valid && !out_stall;
  // Only a final byte needs the result register.
  assign in_stall  = out_valid && out_stall && end_of_frame;
  assign in_accept = in_valid && !in_stall;
  assign keep      = kept_byte_count < CW'(MAX_FRAME_BYTES);

  always_comb begin
    running_crc_next      = running_crc;
    kept_byte_count_next  = kept_byte_count;
    trailer_delay_next    = trailer_delay;
    reading_bytes_next    = reading_bytes;
    if (keep) begin
      if (kept_byte_count >= CW'(2)) begin
        running_crc_next = crc_feed(running_crc, trailer_delay[0]);
      end
      trailer_delay_next[0] = trailer_delay[1];
      trailer_delay_next[1] = rx_byte;
      for (int i = 0; i < READ_COUNT; i++) begin
        if (kept_byte_count == CW'(READ_FIRST + i)) begin
          reading_bytes_next[i] = rx_byte;
        end
      end
      kept_byte_count_next = kept_byte_count + CW'(1);
    end
  end

  always_comb begin
    recv_next = {trailer_delay_next[1], trailer_delay_next[0]};
    priority if (LW'(kept_byte_count_next) < LW'(min_frame_length)) begin
      status_next = STATUS_SHORT;
    end else if (running_crc_next != recv_next) begin
      status_next = STATUS_CRC_BAD;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_length <= MIN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_frame_length <= cfg_data;
    end
  end

  // Frame state: advances on every accepted byte up to MAX_FRAME_BYTES and returns to
  // its start after a final byte.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && end_of_frame)) begin
      running_crc     <= CRC_INIT;
      kept_byte_count <= '0;
      trailer_delay   <= '{default: 8'd0};
      reading_bytes   <= '{default: 8'd0};
    end else if (in_accept) begin
      running_crc     <= running_crc_next;
      kept_byte_count <= kept_byte_count_next;
      trailer_delay   <= trailer_delay_next;
      reading_bytes   <= reading_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && end_of_frame) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_frame) begin
      frame_status     <= status_next;
      crc_computed     <= running_crc_next;
      crc_received     <= recv_next;
      voltage_raw      <= {reading_bytes_next[0],  reading_bytes_next[1]};
      current_raw      <= {reading_bytes_next[2],  reading_bytes_next[3]};
      power_raw        <= {reading_bytes_next[4],  reading_bytes_next[5]};
      energy_raw       <= {reading_bytes_next[6],  reading_bytes_next[7]};
      frequency_raw    <= {reading_bytes_next[8],  reading_bytes_next[9]};
      power_factor_raw <= {reading_bytes_next[10], reading_bytes_next[11]};
    end
  end

endmodule

// ===== sv/mrc_checker.sv =====
// Port-level assertions for the Modbus RTU reply checker, bound to its top level.
// Depends on mrc_pkg and modbus_response_checker_unit_assert.svh.
`include "modbus_response_checker_unit_assert.svh"

module mrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_frame,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  frame_status,
  input logic [15:0] crc_computed,
  input logic [15:0] crc_received
);
  import mrc_pkg::*;

  logic        last_take;
  logic        out_take;
  logic        out_wait;
  logic        ok_word;
  logic [33:0] word_view;

  assign last_take = in_valid && !in_stall && end_of_frame;
  assign out_take  = out_valid && !out_stall;
  assign out_wait  = out_valid && out_stall;
  assign ok_word   = out_valid && (frame_status == STATUS_OK);
  assign word_view = {frame_status, crc_computed, crc_received};

  // A result appears only after a final byte was taken.
  `MRC_ASSERT_SAME(a_rise_needs_last, clk, rst, $rose(out_valid), $past(last_take))
  // A result that is taken is not followed by another unless a final byte came in.
  `MRC_ASSERT_NEXT(a_no_extra_result, clk, rst, out_take && !last_take, !out_valid)
  // An ok status means the two CRC values agree.
  `MRC_ASSERT_SAME(a_ok_means_match, clk, rst, ok_word, crc_computed == crc_received)
  // Input is held back only by a waiting result and a final byte.
  `MRC_ASSERT_SAME(a_stall_cause, clk, rst, in_stall, out_wait && end_of_frame)
  // A stalled result word holds.
  `MRC_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(word_view))

endmodule

bind modbus_response_checker_unit mrc_checker u_mrc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .end_of_frame (end_of_frame),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_status (frame_status),
  .crc_computed (crc_computed),
  .crc_received (crc_received)
);
